// ===== src/av1_reference_frame_selector_core_assert.svh =====
// ---------------------------------------------------------------------------
// Reference frame selector assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef AV1_REFERENCE_FRAME_SELECTOR_CORE_ASSERT_SVH
`define AV1_REFERENCE_FRAME_SELECTOR_CORE_ASSERT_SVH

// property that must hold in the same cycle as its trigger
`define AV1RFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// property that must hold in the cycle after its trigger
`define AV1RFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/av1rfs_pkg.sv =====
// ---------------------------------------------------------------------------
// Reference frame selector package
// Item types, lane result type and small helpers shared by the selector.
// ---------------------------------------------------------------------------
package av1rfs_pkg;

	localparam int SLOTS  = 8;
	localparam int SLOT_W = 3;
	localparam int HINT_W = 8;
	localparam int BITS_W = 4;

	// places in the forward fill order
	localparam logic [2:0] FILL_LAST2   = 3'd0;
	localparam logic [2:0] FILL_LAST3   = 3'd1;
	localparam logic [2:0] FILL_BWDREF  = 3'd2;
	localparam logic [2:0] FILL_ALTREF2 = 3'd3;
	localparam logic [2:0] FILL_ALTREF  = 3'd4;

	localparam logic [BITS_W-1:0] BITS_RESET = 4'd7;

	typedef struct packed {
		logic [SLOT_W-1:0] last_slot;
		logic [SLOT_W-1:0] golden_slot;
		logic [HINT_W-1:0] current_hint;
		logic [HINT_W-1:0] slot_hint_0;
		logic [HINT_W-1:0] slot_hint_1;
		logic [HINT_W-1:0] slot_hint_2;
		logic [HINT_W-1:0] slot_hint_3;
		logic [HINT_W-1:0] slot_hint_4;
		logic [HINT_W-1:0] slot_hint_5;
		logic [HINT_W-1:0] slot_hint_6;
		logic [HINT_W-1:0] slot_hint_7;
	} req_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] ref_last;
		logic [SLOT_W-1:0] ref_last2;
		logic [SLOT_W-1:0] ref_last3;
		logic [SLOT_W-1:0] ref_golden;
		logic [SLOT_W-1:0] ref_bwdref;
		logic [SLOT_W-1:0] ref_altref2;
		logic [SLOT_W-1:0] ref_altref;
		logic              last_not_conformant;
		logic              golden_not_conformant;
	} rsp_item_t;

	// what one lane found about its slot
	typedef struct packed {
		logic              cand_b;  // unused backward slot
		logic              cand_f;  // unused forward slot
		logic [SLOT_W-1:0] e_rank;  // place among backward slots, earliest first
		logic [SLOT_W-1:0] f_rank;  // place among forward slots, latest first
		logic              is_min;  // smallest shifted hint, lowest slot on ties
	} lane_rank_t;

	// midpoint of the hint range; width clamped to 1..8
	function automatic logic [HINT_W-1:0] hint_mid(input logic [BITS_W-1:0] bits);
		logic [BITS_W-1:0] b;
		if (bits == '0)
			b = 4'd1;
		else if (bits > 4'd8)
			b = 4'd8;
		else
			b = bits;
		return 8'd1 << (b - 4'd1);
	endfunction

	function automatic logic [BITS_W-1:0] popcnt8(input logic [SLOTS-1:0] v);
		logic [BITS_W-1:0] n;
		n = '0;
		for (int i = 0; i < SLOTS; i++)
			n = n + {3'd0, v[i]};
		return n;
	endfunction

endpackage

// ===== src/av1rfs_hint_lane.sv =====
// ---------------------------------------------------------------------------
// Reference frame selector hint lane
// Shifted order hint and direction of one reference slot.
// ---------------------------------------------------------------------------
module av1rfs_hint_lane (
	input  logic [av1rfs_pkg::HINT_W-1:0] hint,
	input  logic [av1rfs_pkg::HINT_W-1:0] cur,
	input  logic [av1rfs_pkg::HINT_W-1:0] mid,
	output logic [av1rfs_pkg::HINT_W-1:0] sh,
	output logic                          back
);

	logic [av1rfs_pkg::HINT_W-1:0] d;
	logic                          neg;

	// wrapped distance; bits above the hint width fall out via the masks
	assign d    = hint - cur;
	assign neg  = (d & mid) != '0;
	assign back = !neg;
	assign sh   = (neg ? '0 : mid) | (d & (mid - 8'd1));

endmodule

// ===== src/av1rfs_rank_lane.sv =====
// ---------------------------------------------------------------------------
// Reference frame selector rank lane
// Places one slot in the backward, forward and overall hint orderings.
// ---------------------------------------------------------------------------
module av1rfs_rank_lane (
	input  logic [av1rfs_pkg::SLOT_W-1:0]                         lane_idx,
	input  logic [av1rfs_pkg::SLOTS-1:0][av1rfs_pkg::HINT_W-1:0] sh,
	input  logic [av1rfs_pkg::SLOTS-1:0]                          back,
	input  logic [av1rfs_pkg::SLOTS-1:0]                          used,
	output av1rfs_pkg::lane_rank_t                                rank
);

	logic [av1rfs_pkg::HINT_W-1:0] own;
	logic [av1rfs_pkg::SLOTS-1:0]  cb;
	logic [av1rfs_pkg::SLOTS-1:0]  cf;
	logic [av1rfs_pkg::SLOTS-1:0]  e_beat;
	logic [av1rfs_pkg::SLOTS-1:0]  f_beat;
	logic [av1rfs_pkg::SLOTS-1:0]  m_beat;
	logic [av1rfs_pkg::BITS_W-1:0] e_cnt;
	logic [av1rfs_pkg::BITS_W-1:0] f_cnt;

	assign cb  = back & ~used;
	assign cf  = ~back & ~used;
	assign own = sh[lane_idx];

	always_comb begin
		for (int j = 0; j < av1rfs_pkg::SLOTS; j++) begin
			logic other, lower, less, more, same;
			other = 3'(j) != lane_idx;
			lower = 3'(j) < lane_idx;
			less  = sh[j] < own;
			more  = sh[j] > own;
			same  = sh[j] == own;
			e_beat[j] = cb[j] && other && (less || (same && lower));
			f_beat[j] = cf[j] && other && (more || (same && !lower));
			m_beat[j] = other && (less || (same && lower));
		end
	end

	// at most seven others can come first, so three bits hold the place
	assign e_cnt = av1rfs_pkg::popcnt8(e_beat);
	assign f_cnt = av1rfs_pkg::popcnt8(f_beat);

	assign rank.cand_b = cb[lane_idx];
	assign rank.cand_f = cf[lane_idx];
	assign rank.e_rank = e_cnt[av1rfs_pkg::SLOT_W-1:0];
	assign rank.f_rank = f_cnt[av1rfs_pkg::SLOT_W-1:0];
	assign rank.is_min = m_beat == '0;

endmodule

// ===== src/av1rfs_merge.sv =====
// ---------------------------------------------------------------------------
// Reference frame selector merge
// Turns the lane rankings into the seven reference slot choices.
// ---------------------------------------------------------------------------
module av1rfs_merge (
	input  av1rfs_pkg::lane_rank_t [av1rfs_pkg::SLOTS-1:0] ranks,
	input  logic [av1rfs_pkg::SLOT_W-1:0]                  last_slot,
	input  logic [av1rfs_pkg::SLOT_W-1:0]                  golden_slot,
	input  logic                                           last_back,
	input  logic                                           golden_back,
	output av1rfs_pkg::rsp_item_t                          rsp
);

	logic [av1rfs_pkg::SLOTS-1:0]                          cb;
	logic [av1rfs_pkg::SLOTS-1:0]                          cf;
	logic [av1rfs_pkg::SLOTS-1:0][av1rfs_pkg::SLOT_W-1:0] er;
	logic [av1rfs_pkg::SLOTS-1:0][av1rfs_pkg::SLOT_W-1:0] fr;
	logic [av1rfs_pkg::SLOT_W-1:0]                         min_idx;
	logic [av1rfs_pkg::BITS_W-1:0]                         nb;
	logic [av1rfs_pkg::BITS_W-1:0]                         nb_m1;
	logic [av1rfs_pkg::BITS_W-1:0]                         nf;
	logic                                                  alt_set;
	logic                                                  bwd_set;
	logic                                                  alt2_set;
	logic [2:0]                                            alt2_pos;

	function automatic logic [av1rfs_pkg::SLOT_W-1:0] pick(
		input logic [av1rfs_pkg::SLOTS-1:0]                          cand,
		input logic [av1rfs_pkg::SLOTS-1:0][av1rfs_pkg::SLOT_W-1:0] rk,
		input logic [av1rfs_pkg::SLOT_W-1:0]                         tgt
	);
		logic [av1rfs_pkg::SLOT_W-1:0] idx;
		idx = '0;
		for (int j = 0; j < av1rfs_pkg::SLOTS; j++)
			if (cand[j] && rk[j] == tgt)
				idx = 3'(j);
		return idx;
	endfunction

	// forward pick for the fill place pos, else the overall minimum
	function automatic logic [av1rfs_pkg::SLOT_W-1:0] fill(
		input logic [2:0]                                            pos,
		input logic [av1rfs_pkg::BITS_W-1:0]                         cnt,
		input logic [av1rfs_pkg::SLOTS-1:0]                          cand,
		input logic [av1rfs_pkg::SLOTS-1:0][av1rfs_pkg::SLOT_W-1:0] rk,
		input logic [av1rfs_pkg::SLOT_W-1:0]                         fallback
	);
		if ({1'b0, pos} < cnt)
			return pick(cand, rk, pos);
		return fallback;
	endfunction

	always_comb begin
		min_idx = '0;
		for (int j = 0; j < av1rfs_pkg::SLOTS; j++) begin
			cb[j] = ranks[j].cand_b;
			cf[j] = ranks[j].cand_f;
			er[j] = ranks[j].e_rank;
			fr[j] = ranks[j].f_rank;
			if (ranks[j].is_min)
				min_idx = 3'(j);
		end
	end

	assign nb       = av1rfs_pkg::popcnt8(cb);
	assign nf       = av1rfs_pkg::popcnt8(cf);
	assign nb_m1    = nb - 4'd1;
	// the latest backward slot is the last one in earliest-first order
	assign alt_set  = nb != '0;
	assign bwd_set  = nb >= 4'd2;
	assign alt2_set = nb >= 4'd3;
	assign alt2_pos = bwd_set ? av1rfs_pkg::FILL_BWDREF : av1rfs_pkg::FILL_ALTREF2;

	always_comb begin
		rsp.ref_last   = last_slot;
		rsp.ref_golden = golden_slot;
		rsp.ref_last2  = fill(av1rfs_pkg::FILL_LAST2, nf, cf, fr, min_idx);
		rsp.ref_last3  = fill(av1rfs_pkg::FILL_LAST3, nf, cf, fr, min_idx);
		rsp.ref_altref = alt_set ? pick(cb, er, nb_m1[av1rfs_pkg::SLOT_W-1:0])
		                         : fill(av1rfs_pkg::FILL_ALTREF, nf, cf, fr, min_idx);
		rsp.ref_bwdref = bwd_set ? pick(cb, er, 3'd0)
		                         : fill(av1rfs_pkg::FILL_BWDREF, nf, cf, fr, min_idx);
		rsp.ref_altref2 = alt2_set ? pick(cb, er, 3'd1)
		                           : fill(alt2_pos, nf, cf, fr, min_idx);
		rsp.last_not_conformant   = last_back;
		rsp.golden_not_conformant = golden_back;
	end

endmodule

// ===== src/av1_reference_frame_selector_core.sv =====
// ---------------------------------------------------------------------------
// AV1 reference frame selector
// Three-stage pipeline filling the seven reference slots of a frame header.
// ---------------------------------------------------------------------------
// Takes one item per clock while req_stall is low and passes it through the stages
// in turn (shifted hints, then per-slot ranking, then the output register), so
// back-to-back items stream at one a cycle unless a stall holds them. Eight lanes
// work on the eight slots at once; each lane ranks its own slot against the others
// with parallel comparators and the merge stage reads the choices off the ranks.
// A stall on the result side holds each stage only once the stage after it is
// full. The user must write order_hint_bits through cfg_we/cfg_wdata only while
// the block is idle, which it does not enforce; 0 is taken as 1 and values above 8 as 8.
module av1_reference_frame_selector_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [av1rfs_pkg::BITS_W-1:0]        cfg_wdata,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  av1rfs_pkg::req_item_t                req_item,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output av1rfs_pkg::rsp_item_t                rsp_item
);

	logic [av1rfs_pkg::HINT_W-1:0] mid_q;

	logic [av1rfs_pkg::SLOTS-1:0][av1rfs_pkg::HINT_W-1:0] hints;
	logic [av1rfs_pkg::SLOTS-1:0][av1rfs_pkg::HINT_W-1:0] sh;
	logic [av1rfs_pkg::SLOTS-1:0]                          back;

	logic                                                  v_s1;
	logic [av1rfs_pkg::SLOTS-1:0][av1rfs_pkg::HINT_W-1:0] sh_s1;
	logic [av1rfs_pkg::SLOTS-1:0]                          back_s1;
	logic [av1rfs_pkg::SLOT_W-1:0]                         last_s1;
	logic [av1rfs_pkg::SLOT_W-1:0]                         golden_s1;
	logic [av1rfs_pkg::SLOTS-1:0]                          used;

	av1rfs_pkg::lane_rank_t [av1rfs_pkg::SLOTS-1:0] ranks;
	logic                                           v_s2;
	av1rfs_pkg::lane_rank_t [av1rfs_pkg::SLOTS-1:0] ranks_s2;
	logic [av1rfs_pkg::SLOT_W-1:0]                  last_s2;
	logic [av1rfs_pkg::SLOT_W-1:0]                  golden_s2;
	logic                                           last_back_s2;
	logic                                           golden_back_s2;
	logic [av1rfs_pkg::SLOTS-1:0]                   min_vec_s2;

	av1rfs_pkg::rsp_item_t merged;

	logic rdy1;
	logic rdy2;
	logic rdy3;

	assign rdy3      = !rsp_valid || !rsp_stall;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign req_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mid_q <= av1rfs_pkg::hint_mid(av1rfs_pkg::BITS_RESET);
		else if (cfg_we)
			mid_q <= av1rfs_pkg::hint_mid(cfg_wdata);
	end

	assign hints[0] = req_item.slot_hint_0;
	assign hints[1] = req_item.slot_hint_1;
	assign hints[2] = req_item.slot_hint_2;
	assign hints[3] = req_item.slot_hint_3;
	assign hints[4] = req_item.slot_hint_4;
	assign hints[5] = req_item.slot_hint_5;
	assign hints[6] = req_item.slot_hint_6;
	assign hints[7] = req_item.slot_hint_7;

	for (genvar i = 0; i < av1rfs_pkg::SLOTS; i++) begin : g_hint
		av1rfs_hint_lane u_hint (
			.hint (hints[i]),
			.cur  (req_item.current_hint),
			.mid  (mid_q),
			.sh   (sh[i]),
			.back (back[i])
		);
	end

	// stage 1: shifted hints
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy1)
			v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && req_valid) begin
			sh_s1     <= sh;
			back_s1   <= back;
			last_s1   <= req_item.last_slot;
			golden_s1 <= req_item.golden_slot;
		end
	end

	always_comb begin
		for (int j = 0; j < av1rfs_pkg::SLOTS; j++)
			used[j] = (3'(j) == last_s1) || (3'(j) == golden_s1);
	end

	for (genvar i = 0; i < av1rfs_pkg::SLOTS; i++) begin : g_rank
		av1rfs_rank_lane u_rank (
			.lane_idx (3'(i)),
			.sh       (sh_s1),
			.back     (back_s1),
			.used     (used),
			.rank     (ranks[i])
		);
	end

	// stage 2: lane rankings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ranks_s2       <= ranks;
			last_s2        <= last_s1;
			golden_s2      <= golden_s1;
			last_back_s2   <= back_s1[last_s1];
			golden_back_s2 <= back_s1[golden_s1];
		end
	end

	always_comb begin
		for (int j = 0; j < av1rfs_pkg::SLOTS; j++)
			min_vec_s2[j] = ranks_s2[j].is_min;
	end

	av1rfs_merge u_merge (
		.ranks       (ranks_s2),
		.last_slot   (last_s2),
		.golden_slot (golden_s2),
		.last_back   (last_back_s2),
		.golden_back (golden_back_s2),
		.rsp         (merged)
	);

	// stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid <= 1'b0;
		else if (rdy3)
			rsp_valid <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2)
			rsp_item <= merged;
	end

	`include "av1_reference_frame_selector_core_assert.svh"

	`AV1RFS_ASSERT_NOW(a_empty_takes, !v_s1, !req_stall, "empty first stage stalled the input")
	`AV1RFS_ASSERT_NEXT(a_s1_holds, v_s1 && !rdy2, v_s1 && $stable(sh_s1) && $stable(last_s1), "stage 1 item lost while held")
	`AV1RFS_ASSERT_NOW(a_one_min, v_s2, $countones(min_vec_s2) == 1, "minimum hint not unique")
	`AV1RFS_ASSERT_NOW(a_last_kept, v_s2, merged.ref_last == last_s2, "merge changed LAST")

endmodule
